>>> rtl/dcwa_pkg.sv
// Shared codes, types and BCD helpers for the digital clock with alarm.
package dcwa_pkg;

  localparam int unsigned ReqTypeWidth   = 3;
  localparam int unsigned DigitWidth     = 4;
  localparam int unsigned HoursWidth     = 5;
  localparam int unsigned MinutesWidth   = 6;
  localparam int unsigned SecondsWidth   = 6;
  localparam int unsigned ModeCodeWidth  = 2;
  localparam int unsigned TickWidth      = 8;
  localparam int unsigned DayHoursWidth  = 5;
  localparam int unsigned NumDigits      = 6;
  localparam int unsigned PosWidth       = 3;
  localparam int unsigned PaddrWidth     = 3;
  localparam int unsigned PdataWidth     = 32;

  localparam logic [TickWidth-1:0]     TicksPerSecondReset = 8'd20;
  localparam logic [DayHoursWidth-1:0] DayHoursReset       = 5'd24;
  localparam logic [MinutesWidth-1:0]  MinutesPerHour      = 6'd60;
  localparam logic [SecondsWidth-1:0]  SecondsPerMinute    = 6'd60;

  localparam logic [ReqTypeWidth-1:0] REQ_TICK      = 3'd0;
  localparam logic [ReqTypeWidth-1:0] REQ_SET_TIME  = 3'd1;
  localparam logic [ReqTypeWidth-1:0] REQ_RESUME    = 3'd2;
  localparam logic [ReqTypeWidth-1:0] REQ_SET_ALARM = 3'd3;
  localparam logic [ReqTypeWidth-1:0] REQ_CANCEL    = 3'd4;
  localparam logic [ReqTypeWidth-1:0] REQ_DIGIT     = 3'd5;

  localparam logic [ModeCodeWidth-1:0] MODE_CODE_RUN       = 2'd0;
  localparam logic [ModeCodeWidth-1:0] MODE_CODE_SET_TIME  = 2'd1;
  localparam logic [ModeCodeWidth-1:0] MODE_CODE_SET_ALARM = 2'd2;

  localparam logic [PosWidth-1:0] POS_HOUR_TENS = 3'd0;
  localparam logic [PosWidth-1:0] POS_HOUR_ONES = 3'd1;
  localparam logic [PosWidth-1:0] POS_MIN_TENS  = 3'd2;
  localparam logic [PosWidth-1:0] POS_MIN_ONES  = 3'd3;
  localparam logic [PosWidth-1:0] POS_SEC_TENS  = 3'd4;
  localparam logic [PosWidth-1:0] POS_SEC_ONES  = 3'd5;
  localparam logic [PosWidth-1:0] POS_DONE      = 3'd6;

  localparam logic [0:0] REG_TICKS_PER_SECOND = 1'b0;
  localparam logic [0:0] REG_DAY_HOURS        = 1'b1;

  typedef enum logic [2:0] {
    MODE_RUN       = 3'b001,
    MODE_SET_TIME  = 3'b010,
    MODE_SET_ALARM = 3'b100
  } mode_t;

  // Digit 0 is hour tens, digit 5 is second ones.
  typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_t;

  typedef struct packed {
    logic [DigitWidth-1:0] tens;
    logic [DigitWidth-1:0] ones;
  } bcd_pair_t;

  function automatic logic [6:0] bcd_value(input logic [DigitWidth-1:0] tens,
                                           input logic [DigitWidth-1:0] ones);
    bcd_value = 7'(tens) * 7'd10 + 7'(ones);
  endfunction

  // Split a value of at most 59 into two BCD digits.
  function automatic bcd_pair_t bcd_split(input logic [5:0] v);
    bcd_pair_t  p;
    logic [5:0] base;
    if (v >= 6'd50) begin
      p.tens = 4'd5;
      base   = 6'd50;
    end else if (v >= 6'd40) begin
      p.tens = 4'd4;
      base   = 6'd40;
    end else if (v >= 6'd30) begin
      p.tens = 4'd3;
      base   = 6'd30;
    end else if (v >= 6'd20) begin
      p.tens = 4'd2;
      base   = 6'd20;
    end else if (v >= 6'd10) begin
      p.tens = 4'd1;
      base   = 6'd10;
    end else begin
      p.tens = 4'd0;
      base   = 6'd0;
    end
    p.ones    = 4'(v - base);
    bcd_split = p;
  endfunction

  function automatic logic [HoursWidth-1:0] next_hour(
    input logic [HoursWidth-1:0]    hours,
    input logic [DayHoursWidth-1:0] day_hours
  );
    logic [HoursWidth:0] n;
    n = {1'b0, hours} + 6'd1;
    next_hour = (n >= {1'b0, day_hours}) ? '0 : HoursWidth'(n);
  endfunction

  function automatic logic digit_allowed(input logic [PosWidth-1:0]   pos,
                                         input logic [DigitWidth-1:0] d,
                                         input logic [DigitWidth-1:0] hour_tens);
    logic ok;
    unique case (pos)
      POS_HOUR_TENS: ok = (d <= 4'd2);
      POS_HOUR_ONES: ok = (hour_tens < 4'd2) ? (d <= 4'd9) : (d <= 4'd3);
      POS_MIN_TENS:  ok = (d <= 4'd5);
      POS_MIN_ONES:  ok = (d <= 4'd9);
      POS_SEC_TENS:  ok = (d <= 4'd5);
      POS_SEC_ONES:  ok = (d <= 4'd9);
      default:       ok = 1'b0;
    endcase
    digit_allowed = ok;
  endfunction

endpackage

>>> rtl/dcwa_if.sv
// Request and result channel interfaces for the digital clock with alarm.
interface dcwa_req_if;
  logic                                valid;
  logic                                ready;
  logic [dcwa_pkg::ReqTypeWidth-1:0]   req_type;
  logic [dcwa_pkg::DigitWidth-1:0]     digit_value;

  modport source (output valid, output req_type, output digit_value, input ready);
  modport sink   (input valid, input req_type, input digit_value, output ready);
endinterface

interface dcwa_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [dcwa_pkg::HoursWidth-1:0]      shown_hours;
  logic [dcwa_pkg::MinutesWidth-1:0]    shown_minutes;
  logic [dcwa_pkg::SecondsWidth-1:0]    shown_seconds;
  logic                                 buzzer_on;
  logic [dcwa_pkg::ModeCodeWidth-1:0]   current_mode;
  logic                                 alarm_armed;

  modport source (output valid, output shown_hours, output shown_minutes,
                  output shown_seconds, output buzzer_on, output current_mode,
                  output alarm_armed, input ready);
  modport sink   (input valid, input shown_hours, input shown_minutes,
                  input shown_seconds, input buzzer_on, input current_mode,
                  input alarm_armed, output ready);
endinterface

>>> rtl/digital_clock_with_alarm.sv
// Top level: BCD hh:mm:ss clock with alarm, APB configuration and result register.
// The result of an accepted request beat is registered and offered in the cycle after it.
// Throughput: one request beat per cycle while results are taken; the result register frees as it is taken.
// The clock, alarm and buzzer update in a single pass of BCD carry logic.
// Reset (rst, synchronous): running mode, 00:00:00, alarm 00:00:00 disarmed,
// buzzer off, 20 ticks per second, 24-hour day, result register empty.
module digital_clock_with_alarm (
  input  logic                                clk,
  input  logic                                rst,
  dcwa_req_if.sink                            req,
  dcwa_res_if.source                          res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcwa_pkg::PaddrWidth-1:0]     paddr,
  input  logic [dcwa_pkg::PdataWidth-1:0]     pwdata,
  output logic [dcwa_pkg::PdataWidth-1:0]     prdata,
  output logic                                pready
);

  logic [dcwa_pkg::TickWidth-1:0]     ticks_per_second;
  logic [dcwa_pkg::DayHoursWidth-1:0] day_hours;

  dcwa_pkg::mode_t                    mode, mode_next;
  logic [dcwa_pkg::TickWidth-1:0]     tick_count, tick_count_next;
  dcwa_pkg::digits_t                  time_digits, time_digits_next;
  dcwa_pkg::digits_t                  alarm_digits, alarm_digits_next;
  logic [dcwa_pkg::PosWidth-1:0]      entry_position, entry_position_next;
  logic                               armed_flag, armed_flag_next;
  logic                               buzzer_flag, buzzer_flag_next;

  logic [dcwa_pkg::HoursWidth-1:0]    shown_hours_next;
  logic [dcwa_pkg::MinutesWidth-1:0]  shown_minutes_next;
  logic [dcwa_pkg::SecondsWidth-1:0]  shown_seconds_next;
  logic [dcwa_pkg::ModeCodeWidth-1:0] mode_code_next;

  logic req_beat;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign req.ready = !res.valid || res.ready;
  assign req_beat  = req.valid && req.ready;

  always_comb begin
    unique case (paddr[2])
      dcwa_pkg::REG_TICKS_PER_SECOND: prdata = 32'(ticks_per_second);
      dcwa_pkg::REG_DAY_HOURS:        prdata = 32'(day_hours);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= dcwa_pkg::TicksPerSecondReset;
      day_hours        <= dcwa_pkg::DayHoursReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        dcwa_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= pwdata[7:0];
        dcwa_pkg::REG_DAY_HOURS:        day_hours        <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    logic [dcwa_pkg::TickWidth-1:0]    tick_inc;
    logic [dcwa_pkg::SecondsWidth-1:0] sec;
    logic [dcwa_pkg::MinutesWidth-1:0] mins;
    logic [dcwa_pkg::HoursWidth-1:0]   hrs;
    dcwa_pkg::bcd_pair_t               pair;
    dcwa_pkg::digits_t                 target;
    logic [dcwa_pkg::HoursWidth-1:0]   th, ah, oh;
    logic [dcwa_pkg::MinutesWidth-1:0] tm, am, om;
    logic [dcwa_pkg::SecondsWidth-1:0] ts, as_v;
    logic [dcwa_pkg::MinutesWidth:0]   am_inc;
    dcwa_pkg::digits_t                 shown;

    mode_next           = mode;
    tick_count_next     = tick_count;
    time_digits_next    = time_digits;
    alarm_digits_next   = alarm_digits;
    entry_position_next = entry_position;
    armed_flag_next     = armed_flag;
    buzzer_flag_next    = buzzer_flag;
    pair                = '0;
    tick_inc            = tick_count + 8'd1;
    sec  = 6'(dcwa_pkg::bcd_value(time_digits[4], time_digits[5])) + 6'd1;
    mins = 6'(dcwa_pkg::bcd_value(time_digits[2], time_digits[3])) + 6'd1;
    hrs  = dcwa_pkg::next_hour(5'(dcwa_pkg::bcd_value(time_digits[0], time_digits[1])),
                               day_hours);
    target = (mode == dcwa_pkg::MODE_SET_ALARM) ? alarm_digits : time_digits;

    unique case (req.req_type)
      dcwa_pkg::REQ_TICK: begin
        if (mode == dcwa_pkg::MODE_RUN) begin
          if (tick_inc == ticks_per_second) begin
            tick_count_next = '0;
            if (sec >= dcwa_pkg::SecondsPerMinute) begin
              sec = '0;
              if (mins >= dcwa_pkg::MinutesPerHour) begin
                mins = '0;
                pair = dcwa_pkg::bcd_split(6'(hrs));
                time_digits_next[0] = pair.tens;
                time_digits_next[1] = pair.ones;
              end
              pair = dcwa_pkg::bcd_split(mins);
              time_digits_next[2] = pair.tens;
              time_digits_next[3] = pair.ones;
            end
            pair = dcwa_pkg::bcd_split(sec);
            time_digits_next[4] = pair.tens;
            time_digits_next[5] = pair.ones;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      dcwa_pkg::REQ_SET_TIME: begin
        mode_next           = dcwa_pkg::MODE_SET_TIME;
        entry_position_next = '0;
      end
      dcwa_pkg::REQ_RESUME: begin
        mode_next           = dcwa_pkg::MODE_RUN;
        entry_position_next = '0;
      end
      dcwa_pkg::REQ_SET_ALARM: begin
        mode_next           = dcwa_pkg::MODE_SET_ALARM;
        entry_position_next = '0;
        armed_flag_next     = 1'b1;
      end
      dcwa_pkg::REQ_CANCEL: begin
        armed_flag_next  = 1'b0;
        buzzer_flag_next = 1'b0;
      end
      dcwa_pkg::REQ_DIGIT: begin
        if (mode != dcwa_pkg::MODE_RUN && entry_position < dcwa_pkg::POS_DONE &&
            dcwa_pkg::digit_allowed(entry_position, req.digit_value, target[0])) begin
          target[entry_position] = req.digit_value;
          entry_position_next    = entry_position + 3'd1;
          if (mode == dcwa_pkg::MODE_SET_ALARM) begin
            alarm_digits_next = target;
          end else begin
            time_digits_next  = target;
          end
        end
      end
      default: begin
      end
    endcase

    th   = 5'(dcwa_pkg::bcd_value(time_digits_next[0], time_digits_next[1]));
    tm   = 6'(dcwa_pkg::bcd_value(time_digits_next[2], time_digits_next[3]));
    ts   = 6'(dcwa_pkg::bcd_value(time_digits_next[4], time_digits_next[5]));
    ah   = 5'(dcwa_pkg::bcd_value(alarm_digits_next[0], alarm_digits_next[1]));
    am   = 6'(dcwa_pkg::bcd_value(alarm_digits_next[2], alarm_digits_next[3]));
    as_v = 6'(dcwa_pkg::bcd_value(alarm_digits_next[4], alarm_digits_next[5]));
    am_inc = {1'b0, am} + 7'd1;
    if (am_inc >= {1'b0, dcwa_pkg::MinutesPerHour}) begin
      om = '0;
      oh = dcwa_pkg::next_hour(ah, day_hours);
    end else begin
      om = 6'(am_inc);
      oh = ah;
    end
    if (armed_flag_next && th == ah && tm == am && ts == as_v) begin
      buzzer_flag_next = 1'b1;
    end
    if ((th == oh && tm == om && ts == as_v) || !armed_flag_next) begin
      buzzer_flag_next = 1'b0;
    end

    shown = (mode_next == dcwa_pkg::MODE_SET_ALARM) ? alarm_digits_next : time_digits_next;
    shown_hours_next   = 5'(dcwa_pkg::bcd_value(shown[0], shown[1]));
    shown_minutes_next = 6'(dcwa_pkg::bcd_value(shown[2], shown[3]));
    shown_seconds_next = 6'(dcwa_pkg::bcd_value(shown[4], shown[5]));

    unique case (mode_next)
      dcwa_pkg::MODE_RUN:       mode_code_next = dcwa_pkg::MODE_CODE_RUN;
      dcwa_pkg::MODE_SET_TIME:  mode_code_next = dcwa_pkg::MODE_CODE_SET_TIME;
      dcwa_pkg::MODE_SET_ALARM: mode_code_next = dcwa_pkg::MODE_CODE_SET_ALARM;
      default:                  mode_code_next = dcwa_pkg::MODE_CODE_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= dcwa_pkg::MODE_RUN;
      tick_count     <= '0;
      time_digits    <= '0;
      alarm_digits   <= '0;
      entry_position <= '0;
      armed_flag     <= 1'b0;
      buzzer_flag    <= 1'b0;
    end else if (req_beat) begin
      mode           <= mode_next;
      tick_count     <= tick_count_next;
      time_digits    <= time_digits_next;
      alarm_digits   <= alarm_digits_next;
      entry_position <= entry_position_next;
      armed_flag     <= armed_flag_next;
      buzzer_flag    <= buzzer_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (req_beat) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      res.shown_hours   <= shown_hours_next;
      res.shown_minutes <= shown_minutes_next;
      res.shown_seconds <= shown_seconds_next;
      res.buzzer_on     <= buzzer_flag_next;
      res.current_mode  <= mode_code_next;
      res.alarm_armed   <= armed_flag_next;
    end
  end

endmodule
